// ===== hdl/lmsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lmsf_pkg;

    localparam int TAP_COUNT = 32;
    localparam int CNT_W     = $clog2(TAP_COUNT);

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 16;
    localparam int WEIGHT_W = 32;
    // mu * error: unsigned 16 by signed 16 fits 33 signed bits
    localparam int MUE_W    = STEP_W + SAMPLE_W + 1;
    localparam int PROD_W   = MUE_W + SAMPLE_W;
    localparam int ACC_W    = PROD_W + $clog2(TAP_COUNT);

    // Q3.44 sum down to Q1.15, and Q2.46 step down to Q2.29
    localparam int ACC_SHIFT = 29;
    localparam int UPD_SHIFT = 17;
    localparam int YFULL_W   = ACC_W - ACC_SHIFT;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam logic [STEP_W-1:0] STEP_SIZE_RESET = STEP_W'(328);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;

    typedef struct packed {
        logic load;    // write new sample at the head
        logic rotate;  // circulate both lines by one toward the head
        logic wr_upd;  // write back one updated weight
        logic shift;   // advance the delay line toward its tail
    } bank_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/lmsf_tap_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lmsf_tap_bank (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lmsf_pkg::bank_ctrl_t  ctrl,
    input  wire lmsf_pkg::sample_t     new_sample,
    input  wire lmsf_pkg::weight_t     upd_weight,
    output lmsf_pkg::weight_t          head_weight,
    output lmsf_pkg::sample_t          head_tap,
    output lmsf_pkg::weight_t          tail_weight
);

    localparam int N = lmsf_pkg::TAP_COUNT;

    lmsf_pkg::weight_t weight_reg [N];
    lmsf_pkg::sample_t tap_reg    [N];

    assign head_weight = weight_reg[0];
    assign head_tap    = tap_reg[0];
    assign tail_weight = weight_reg[N-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                weight_reg[i] <= '0;
                tap_reg[i]    <= '0;
            end
        end else begin
            if (ctrl.load) begin
                tap_reg[0] <= new_sample;
            end
            if (ctrl.rotate) begin
                for (int i = 0; i < N - 1; i++) begin
                    tap_reg[i] <= tap_reg[i+1];
                end
                for (int i = 0; i < N - 2; i++) begin
                    weight_reg[i] <= weight_reg[i+1];
                end
                // the weight issued last cycle is moving from the tail
                weight_reg[N-2] <= ctrl.wr_upd ? upd_weight : weight_reg[N-1];
                weight_reg[N-1] <= weight_reg[0];
                tap_reg[N-1]    <= tap_reg[0];
            end else if (ctrl.wr_upd) begin
                weight_reg[N-1] <= upd_weight;
            end
            if (ctrl.shift) begin
                for (int i = 1; i < N; i++) begin
                    tap_reg[i] <= tap_reg[i-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lms_adaptive_fir_filter.sv =====
// LMS adaptive FIR filter with one shared multiplier.
//
// Input channel (s_valid/s_ready): one reference sample and one desired
// sample, both signed Q1.15. Result channel (m_valid/m_ready): the filter
// output and the error, both saturated signed Q1.15, one result per input.
// cfg_wr_en/cfg_wr_data write the unsigned Q0.16 step size; write it only
// while the block is idle.
//
// One 33x16 multiplier with a registered product serves the dot product
// (TAP_COUNT steps), mu times error, and the weight updates (TAP_COUNT
// steps). m_valid and s_ready both rise when a result enters the output
// register. s_ready is low while an item is in work, so a new input is
// taken only after the last item is finished.
//
// A finished result sits in the output register; the next input is taken
// while it waits. If the receiver still stalls when the following result is
// ready, the block holds that result internally and stays busy until the
// output register is free. Reset clears weights and delay line to zero, sets
// the step size to 328, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module lms_adaptive_fir_filter (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [15:0]          cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [15:0]   s_reference_sample,
    input  wire logic signed [15:0]   s_desired_sample,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [15:0]        m_filter_output,
    output logic signed [15:0]        m_error_sample
);

    localparam int CNT_W   = lmsf_pkg::CNT_W;
    localparam int MUE_W   = lmsf_pkg::MUE_W;
    localparam int PROD_W  = lmsf_pkg::PROD_W;
    localparam int ACC_W   = lmsf_pkg::ACC_W;
    localparam int YFULL_W = lmsf_pkg::YFULL_W;
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(lmsf_pkg::TAP_COUNT - 1);
    localparam logic [ACC_W-1:0]  ACC_HALF = ACC_W'(64'd1 << (lmsf_pkg::ACC_SHIFT - 1));
    localparam logic [PROD_W-1:0] PROD_HALF = PROD_W'(64'd1 << (lmsf_pkg::UPD_SHIFT - 1));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_DOT_END,
        ST_ROUND,
        ST_ERR,
        ST_MUE,
        ST_MUE_LATCH,
        ST_UPDATE,
        ST_UPD_END,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [lmsf_pkg::STEP_W-1:0]     step_size_reg;
    lmsf_pkg::sample_t               desired_reg;
    lmsf_pkg::sample_t               y_reg;
    lmsf_pkg::sample_t               e_reg;
    logic signed [MUE_W-1:0]         mue_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic                            acc_en_reg;
    logic                            upd_en_reg;
    logic                            m_valid_reg;
    lmsf_pkg::sample_t               m_y_reg;
    lmsf_pkg::sample_t               m_e_reg;

    logic                            in_xfer;
    logic                            out_free;
    logic signed [MUE_W-1:0]         mul_a;
    lmsf_pkg::sample_t               mul_b;
    logic signed [PROD_W-1:0]        prod_next;
    logic [ACC_W-1:0]                acc_rnd;
    logic signed [YFULL_W-1:0]       y_full;
    lmsf_pkg::sample_t               y_next;
    logic signed [lmsf_pkg::SAMPLE_W:0] diff;
    lmsf_pkg::sample_t               e_next;
    logic [PROD_W-1:0]               prod_rnd;
    lmsf_pkg::weight_t               delta;
    logic signed [lmsf_pkg::WEIGHT_W:0] wsum;
    lmsf_pkg::weight_t               upd_weight;
    lmsf_pkg::weight_t               head_weight;
    lmsf_pkg::weight_t               tail_weight;
    lmsf_pkg::sample_t               head_tap;
    lmsf_pkg::bank_ctrl_t            bank_ctrl;

    assign s_ready         = (state_reg == ST_IDLE);
    assign in_xfer         = s_valid && s_ready;
    assign out_free        = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_filter_output = m_y_reg;
    assign m_error_sample  = m_e_reg;

    assign bank_ctrl.load   = in_xfer;
    assign bank_ctrl.rotate = (state_reg == ST_DOT) || (state_reg == ST_UPDATE);
    assign bank_ctrl.wr_upd = upd_en_reg;
    assign bank_ctrl.shift  = (state_reg == ST_SHIFT);

    lmsf_tap_bank u_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (bank_ctrl),
        .new_sample  (s_reference_sample),
        .upd_weight  (upd_weight),
        .head_weight (head_weight),
        .head_tap    (head_tap),
        .tail_weight (tail_weight)
    );

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            ST_DOT: begin
                mul_a = MUE_W'(head_weight);
                mul_b = head_tap;
            end
            ST_MUE: begin
                mul_a = MUE_W'({1'b0, step_size_reg});
                mul_b = e_reg;
            end
            ST_UPDATE: begin
                mul_a = mue_reg;
                mul_b = head_tap;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // output: round half up, then saturate
    assign acc_rnd = acc_reg + ACC_HALF;
    assign y_full  = acc_rnd[ACC_W-1:lmsf_pkg::ACC_SHIFT];

    always_comb begin
        if (y_full > lmsf_pkg::SAMPLE_MAX) begin
            y_next = lmsf_pkg::sample_t'(lmsf_pkg::SAMPLE_MAX);
        end else if (y_full < lmsf_pkg::SAMPLE_MIN) begin
            y_next = lmsf_pkg::sample_t'(lmsf_pkg::SAMPLE_MIN);
        end else begin
            y_next = lmsf_pkg::sample_t'(y_full);
        end
    end

    assign diff = (lmsf_pkg::SAMPLE_W+1)'(desired_reg) - (lmsf_pkg::SAMPLE_W+1)'(y_reg);

    always_comb begin
        if (diff > lmsf_pkg::SAMPLE_MAX) begin
            e_next = lmsf_pkg::sample_t'(lmsf_pkg::SAMPLE_MAX);
        end else if (diff < lmsf_pkg::SAMPLE_MIN) begin
            e_next = lmsf_pkg::sample_t'(lmsf_pkg::SAMPLE_MIN);
        end else begin
            e_next = lmsf_pkg::sample_t'(diff);
        end
    end

    // weight step: round half up to Q2.29, add, saturate
    assign prod_rnd = prod_reg + PROD_HALF;
    assign delta    = prod_rnd[PROD_W-1:lmsf_pkg::UPD_SHIFT];
    assign wsum     = (lmsf_pkg::WEIGHT_W+1)'(tail_weight) + (lmsf_pkg::WEIGHT_W+1)'(delta);

    always_comb begin
        if (wsum[lmsf_pkg::WEIGHT_W] != wsum[lmsf_pkg::WEIGHT_W-1]) begin
            upd_weight = wsum[lmsf_pkg::WEIGHT_W] ? {1'b1, {(lmsf_pkg::WEIGHT_W-1){1'b0}}}
                                                  : {1'b0, {(lmsf_pkg::WEIGHT_W-1){1'b1}}};
        end else begin
            upd_weight = wsum[lmsf_pkg::WEIGHT_W-1:0];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            step_size_reg <= lmsf_pkg::STEP_SIZE_RESET;
            acc_en_reg    <= 1'b0;
            upd_en_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                step_size_reg <= cfg_wr_data;
            end
            acc_en_reg <= (state_reg == ST_DOT);
            upd_en_reg <= (state_reg == ST_UPDATE);
            if (acc_en_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        desired_reg <= s_desired_sample;
                        acc_reg     <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST) begin
                        state_reg <= ST_DOT_END;
                    end
                end
                ST_DOT_END: begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    y_reg     <= y_next;
                    state_reg <= ST_ERR;
                end
                ST_ERR: begin
                    e_reg     <= e_next;
                    state_reg <= ST_MUE;
                end
                ST_MUE: begin
                    state_reg <= ST_MUE_LATCH;
                end
                ST_MUE_LATCH: begin
                    mue_reg   <= prod_reg[MUE_W-1:0];
                    cnt_reg   <= '0;
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST) begin
                        state_reg <= ST_UPD_END;
                    end
                end
                ST_UPD_END: begin
                    state_reg <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        m_y_reg     <= y_reg;
                        m_e_reg     <= e_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("input taken while an item is in work");

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (acc_reg == '0))
        else $error("accumulator not cleared at input transfer");

    a_phase_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(acc_en_reg && upd_en_reg))
        else $error("accumulate and weight write-back overlap");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!acc_en_reg && !upd_en_reg))
        else $error("datapath active while idle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_filter_output)
                                   && $stable(m_error_sample)))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_lms_adaptive_fir_filter.sv =====
`timescale 1ns / 1ps

module tb_lms_adaptive_fir_filter;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 5;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 2 * lmsf_pkg::TAP_COUNT + 24;
    localparam int ITEMS_PER_PHASE = 272;
    localparam int PHASE_COUNT     = 6;
    localparam longint WEIGHT_MAX  = 64'sh0000_0000_7FFF_FFFF;
    localparam longint WEIGHT_MIN  = -WEIGHT_MAX - 1;
    localparam longint SMP_MAX     = lmsf_pkg::SAMPLE_MAX;
    localparam longint SMP_MIN     = lmsf_pkg::SAMPLE_MIN;

    typedef struct packed {
        lmsf_pkg::sample_t ref_smp;
        lmsf_pkg::sample_t des_smp;
    } sample_pair_t;

    typedef struct packed {
        lmsf_pkg::sample_t y;
        lmsf_pkg::sample_t err;
    } lms_out_t;

    logic                        aclk               = 1'b0;
    logic                        aresetn            = 1'b0;
    logic                        cfg_wr_en          = 1'b0;
    logic [lmsf_pkg::STEP_W-1:0] cfg_wr_data        = '0;
    logic                        s_valid            = 1'b0;
    logic                        s_ready;
    lmsf_pkg::sample_t           s_reference_sample = '0;
    lmsf_pkg::sample_t           s_desired_sample   = '0;
    logic                        m_valid;
    logic                        m_ready            = 1'b0;
    lmsf_pkg::sample_t           m_filter_output;
    lmsf_pkg::sample_t           m_error_sample;

    // predictor state
    lmsf_pkg::weight_t           tap_wts  [lmsf_pkg::TAP_COUNT];
    lmsf_pkg::sample_t           tap_line [lmsf_pkg::TAP_COUNT];
    logic [lmsf_pkg::STEP_W-1:0] step_size_q;

    sample_pair_t        sample_pairs[$];
    lms_out_t            pending_outputs[$];

    int                  src_idle_pct   = 0;
    int                  sink_stall_pct = 0;
    int                  mismatch_count = 0;
    int                  idle_cycles    = 0;
    bit                  in_xfer        = 1'b0;
    bit                  out_xfer       = 1'b0;

    lms_adaptive_fir_filter uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_reference_sample (s_reference_sample),
        .s_desired_sample   (s_desired_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_filter_output    (m_filter_output),
        .m_error_sample     (m_error_sample)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic lms_out_t lms_step(input lmsf_pkg::sample_t ref_in,
                                          input lmsf_pkg::sample_t des_in);
        longint   acc;
        longint   y;
        longint   e;
        longint   d;
        lms_out_t res;
        acc = 0;
        tap_line[0] = ref_in;
        for (int i = 0; i < lmsf_pkg::TAP_COUNT; i++)
            acc += longint'(tap_wts[i]) * longint'(tap_line[i]);
        // arithmetic shift gives the floor
        y = clamp((acc + (longint'(1) << 28)) >>> 29, SMP_MIN, SMP_MAX);
        e = clamp(longint'(des_in) - y, SMP_MIN, SMP_MAX);
        // update against the unshifted line, with the saturated error
        for (int i = 0; i < lmsf_pkg::TAP_COUNT; i++) begin
            d = (longint'(step_size_q) * e * longint'(tap_line[i]) + (longint'(1) << 16)) >>> 17;
            tap_wts[i] = lmsf_pkg::weight_t'(clamp(longint'(tap_wts[i]) + d,
                                                   WEIGHT_MIN, WEIGHT_MAX));
        end
        for (int i = lmsf_pkg::TAP_COUNT - 1; i > 0; i--)
            tap_line[i] = tap_line[i - 1];
        res.y   = lmsf_pkg::sample_t'(y);
        res.err = lmsf_pkg::sample_t'(e);
        return res;
    endfunction

    // input driver: hold the item until its transfer
    always @(negedge aclk) begin
        sample_pair_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_xfer) begin
            if (sample_pairs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = sample_pairs.pop_front();
                s_valid            <= 1'b1;
                s_reference_sample <= nxt.ref_smp;
                s_desired_sample   <= nxt.des_smp;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        lms_out_t got;
        lms_out_t want;
        in_xfer  = aresetn && s_valid && s_ready;
        out_xfer = aresetn && m_valid && m_ready;
        if (!aresetn) begin
            for (int i = 0; i < lmsf_pkg::TAP_COUNT; i++) begin
                tap_wts[i]  = '0;
                tap_line[i] = '0;
            end
            step_size_q = lmsf_pkg::STEP_SIZE_RESET;
        end else begin
            if (cfg_wr_en)
                step_size_q = cfg_wr_data;
            if (in_xfer)
                pending_outputs.push_back(lms_step(s_reference_sample, s_desired_sample));
            if (out_xfer) begin
                got.y   = m_filter_output;
                got.err = m_error_sample;
                if (pending_outputs.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual y=%0d e=%0d",
                             $time, got.y, got.err);
                end else begin
                    want = pending_outputs.pop_front();
                    if (got.y !== want.y) begin
                        mismatch_count++;
                        $display("%0t: filter_output expected %0d, actual %0d",
                                 $time, want.y, got.y);
                    end
                    if (got.err !== want.err) begin
                        mismatch_count++;
                        $display("%0t: error_sample expected %0d, actual %0d",
                                 $time, want.err, got.err);
                    end
                end
            end
        end
        if (in_xfer || out_xfer)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_pair(input longint r, input longint d);
        sample_pair_t p;
        p.ref_smp = lmsf_pkg::sample_t'(clamp(r, SMP_MIN, SMP_MAX));
        p.des_smp = lmsf_pkg::sample_t'(clamp(d, SMP_MIN, SMP_MAX));
        sample_pairs.push_back(p);
    endtask

    task automatic wait_drained();
        while (!(sample_pairs.size() == 0 && !s_valid && pending_outputs.size() == 0))
            @(posedge aclk);
    endtask

    task automatic write_step(input logic [lmsf_pkg::STEP_W-1:0] val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic longint rail_value();
        case ($urandom_range(4))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return 0;
            3: return -1;
            default: return longint'(lmsf_pkg::sample_t'($urandom()));
        endcase
    endfunction

    // mostly a bouncing ramp with a delayed, halved copy as the target,
    // so the weights actually converge; the rest is noise and rail values
    task automatic queue_random(input int count);
        int                mode;
        int                lag;
        int                dir;
        longint            inc;
        longint            osc;
        longint            r;
        longint            d;
        lmsf_pkg::sample_t recent [8];
        for (int i = 0; i < 8; i++)
            recent[i] = '0;
        osc = 0;
        dir = 1;
        inc = longint'($urandom_range(3000, 200));
        lag = $urandom_range(7);
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(99);
            osc += dir * inc;
            if (osc > 24000)
                dir = -1;
            else if (osc < -24000)
                dir = 1;
            if (mode < 55) begin
                r = osc + longint'($urandom_range(512)) - 256;
                d = (longint'(recent[lag]) >>> 1) + longint'($urandom_range(256)) - 128;
            end else if (mode < 80) begin
                r = longint'(lmsf_pkg::sample_t'($urandom()));
                d = longint'(lmsf_pkg::sample_t'($urandom()));
            end else begin
                r = rail_value();
                d = rail_value();
            end
            for (int i = 7; i > 0; i--)
                recent[i] = recent[i - 1];
            recent[0] = lmsf_pkg::sample_t'(clamp(r, SMP_MIN, SMP_MAX));
            queue_pair(r, d);
        end
    endtask

    initial begin
        logic [lmsf_pkg::STEP_W-1:0] phase_steps [PHASE_COUNT];
        int src_pcts  [4];
        int sink_pcts [4];
        phase_steps = '{16'd0, lmsf_pkg::STEP_SIZE_RESET, 16'hFFFF, 16'd4096, 16'd1,
                        16'd12000};
        src_pcts    = '{0, 62, 0, 37};
        sink_pcts   = '{0, 0, 62, 37};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset step size: extremes and an impulse
        queue_pair(0, 0);
        queue_pair(SMP_MAX, SMP_MAX);
        queue_pair(SMP_MIN, SMP_MIN);
        queue_pair(SMP_MAX, SMP_MIN);
        queue_pair(SMP_MIN, SMP_MAX);
        queue_pair(16384, 0);
        repeat (4) queue_pair(0, 1000);

        // largest step: drive weights, output and error into saturation
        write_step(16'hFFFF);
        repeat (5) queue_pair(SMP_MAX, SMP_MIN);
        repeat (4) queue_pair(SMP_MIN, SMP_MIN);
        repeat (3) queue_pair(SMP_MAX, SMP_MAX);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_step(phase_steps[ph]);
            src_idle_pct   = src_pcts[ph % 4];
            sink_stall_pct = sink_pcts[ph % 4];
            queue_random(ITEMS_PER_PHASE);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_outputs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
